@@ rtl/sdta_pkg.sv @@
// sdta_pkg: shared constants for the signed decimal to ASCII converter.
// No dependencies.
package sdta_pkg;

    localparam int VALUE_BITS = 32;
    // decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 0.30103)
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(DIGITS + 1);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef logic [BCD_W-1:0] bcd_t;

endpackage

@@ rtl/signed_decimal_to_ascii.sv @@
// signed_decimal_to_ascii: two's complement integer to decimal ASCII text.
// Depends on sdta_pkg.
//
// One input beat (number) produces 1 to 11 output beats (char_code, last_char): an optional
// '-' then the digits most significant first, no leading zeros, last_char set on the final
// one. The most negative value prints as -2147483648. The input is taken only when the block
// is idle. A single shift-add-3 unit runs once per input bit, then leading zero digits are
// shifted out one per cycle, then characters leave one per cycle through an output register
// while out_stall is low; a stalled character is held.
module signed_decimal_to_ascii (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [31:0] number,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        char_code,
    output logic              last_char
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_TRIM  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [sdta_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [sdta_pkg::LEFT_W-1:0]      left_reg, left_next;
    logic [sdta_pkg::VALUE_BITS-1:0]  mag_reg, mag_next;
    sdta_pkg::bcd_t                   bcd_reg, bcd_next;
    logic                             neg_reg, neg_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       char_code_reg, char_code_next;
    logic                             last_char_reg, last_char_next;

    logic [sdta_pkg::VALUE_BITS-1:0]  in_val;
    logic                             in_neg;
    sdta_pkg::bcd_t                   bcd_adj;
    logic [3:0]                       top_digit;
    logic                             out_free;
    logic                             in_fire;

    assign in_val    = number[sdta_pkg::VALUE_BITS-1:0];
    assign in_neg    = in_val[sdta_pkg::VALUE_BITS-1];
    assign top_digit = bcd_reg[sdta_pkg::BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;

    // add-3 correction on every digit
    always_comb
    begin
        for (int i = 0; i < sdta_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_code_next = char_code_reg;
        last_char_next = last_char_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next   = in_neg;
                    mag_next   = in_neg ? (~in_val + 1'b1) : in_val;
                    bcd_next   = '0;
                    cnt_next   = sdta_pkg::CNT_W'(sdta_pkg::VALUE_BITS);
                    left_next  = sdta_pkg::LEFT_W'(sdta_pkg::DIGITS);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[sdta_pkg::BCD_W-2:0], mag_reg[sdta_pkg::VALUE_BITS-1]};
                mag_next = {mag_reg[sdta_pkg::VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == sdta_pkg::CNT_W'(1))
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (top_digit == 4'd0 && left_reg != sdta_pkg::LEFT_W'(1))
                begin
                    bcd_next  = {bcd_reg[sdta_pkg::BCD_W-5:0], 4'd0};
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = sdta_pkg::CHAR_MINUS;
                    last_char_next = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = sdta_pkg::CHAR_ZERO + {4'd0, top_digit};
                    last_char_next = (left_reg == sdta_pkg::LEFT_W'(1));
                    bcd_next       = {bcd_reg[sdta_pkg::BCD_W-5:0], 4'd0};
                    left_next      = left_reg - 1'b1;
                    if (left_reg == sdta_pkg::LEFT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        char_code_reg <= char_code_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign last_char = last_char_reg;

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == sdta_pkg::CHAR_MINUS)
                   || (char_code >= sdta_pkg::CHAR_ZERO && char_code <= 8'd57))
        else $error("illegal character code");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_code == sdta_pkg::CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last beat");

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (cnt_reg != '0))
        else $error("bit counter underflow");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIM || state_reg == ST_SIGN || state_reg == ST_DIGIT)
            |-> (left_reg != '0))
        else $error("digit counter underflow");

    a_no_beat_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled beat dropped");

endmodule

@@ tb/sv/signed_decimal_to_ascii_tb.sv @@
// signed_decimal_to_ascii_tb: self-checking bench for the signed decimal to ASCII converter.
// Depends on sdta_pkg and signed_decimal_to_ascii. A queue-fed driver, a monitor and
// a scoreboard of predicted characters, run through several idle and stall phases.
module signed_decimal_to_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int PHASE_LEN     = 50;
    localparam int DRAIN_EVERY   = 150;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        logic [31:0] value;
        int          phase;
        bit          drain_first;
    } number_beat_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic signed [31:0] number   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        char_code;
    logic              last_char;

    number_beat_t pending_numbers[$];
    text_char_t   expected_text[$];

    int send_idle_pct[4] = '{0, 60, 0, 37};
    int stall_pct[4]     = '{0, 0, 60, 37};
    int phase            = 0;
    int cycle_count      = 0;
    int errors           = 0;
    bit number_taken     = 1'b0;

    signed_decimal_to_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic flag_mismatch(string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void predict_text(logic [31:0] raw);
        logic [sdta_pkg::VALUE_BITS-1:0] magnitude;
        logic                            negative;
        logic [3:0]                      digits[$];
        text_char_t                      c;
        magnitude = raw[sdta_pkg::VALUE_BITS-1:0];
        negative  = magnitude[sdta_pkg::VALUE_BITS-1];
        if (negative)
            magnitude = ~magnitude + 1'b1;
        do
        begin
            digits.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        if (negative)
        begin
            c.code = sdta_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        foreach (digits[i])
        begin
            c.code = sdta_pkg::CHAR_ZERO + 8'(digits[i]);
            c.last = (i == digits.size() - 1);
            expected_text.push_back(c);
        end
    endfunction

    function automatic logic [31:0] random_number();
        int unsigned     digit_count;
        longint unsigned scale;
        logic [31:0]     lo;
        logic [31:0]     hi;
        logic [31:0]     magnitude;
        case ($urandom_range(3))
            0: return $urandom();
            1:
            begin
                digit_count = $urandom_range(1, 10);
                scale = 1;
                repeat (digit_count - 1) scale = scale * 10;
                lo = (digit_count == 1) ? 32'd0 : 32'(scale);
                hi = (digit_count == 10) ? 32'h7FFF_FFFF : 32'(scale * 10 - 1);
                magnitude = $urandom_range(hi, lo);
                return $urandom_range(1) ? -magnitude : magnitude;
            end
            2: return 32'($urandom_range(40)) - 32'd20;
            default:
                return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(50)
                                         : 32'h8000_0000 + $urandom_range(50);
        endcase
    endfunction

    task automatic queue_number(logic [31:0] value, int ph, bit drain_first);
        number_beat_t b;
        b.value       = value;
        b.phase       = ph;
        b.drain_first = drain_first;
        pending_numbers.push_back(b);
    endtask

    always @(negedge clk)
    begin : drive
        bit           go;
        number_beat_t nxt;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct[phase]);
            if (!in_valid || number_taken)
            begin
                go = 1'b0;
                if (pending_numbers.size() > 0)
                begin
                    nxt   = pending_numbers[0];
                    phase = nxt.phase;
                    if (!(nxt.drain_first && expected_text.size() != 0))
                        go = ($urandom_range(99) >= send_idle_pct[phase]);
                end
                in_valid <= go;
                if (go)
                begin
                    number <= nxt.value;
                    void'(pending_numbers.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin : observe
        text_char_t want;
        cycle_count++;
        number_taken = rst_n && in_valid && !in_stall;
        if (number_taken)
            predict_text(number);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_text.size() == 0)
                flag_mismatch($sformatf("unexpected char 0x%02h last %0b", char_code, last_char));
            else
            begin
                want = expected_text.pop_front();
                if (char_code !== want.code)
                    flag_mismatch($sformatf("char_code 0x%02h, want 0x%02h", char_code, want.code));
                if (last_char !== want.last)
                    flag_mismatch($sformatf("last_char %0b, want %0b", last_char, want.last));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : run
        logic [31:0] corners[$];
        corners = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                    -32'sd1, -32'sd9, -32'sd10, -32'sd100,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                    32'd1000000000, 32'd999999999, -32'sd1000000000, -32'sd999999999,
                    32'd1234567890, -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corners[i])
            queue_number(corners[i], 0, 1'b0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            queue_number(random_number(), (i / PHASE_LEN) % 4, (i % DRAIN_EVERY) == 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || in_valid) @(posedge clk);
        while (expected_text.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sdta_pkg.sv
rtl/signed_decimal_to_ascii.sv
tb/sv/signed_decimal_to_ascii_tb.sv
